// File: src/swamm_pkg.sv
// Package for the sliding window average / min / max block.
// Holds sizes, payload types and the window engine state codes.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package swamm_pkg;

  // window store depth and derived widths
  localparam int WindowMax  = 1024;
  localparam int AddrW      = $clog2(WindowMax);
  localparam int LenW       = $clog2(WindowMax + 1);
  localparam int CfgW       = 11;
  localparam int TempW      = 9;
  localparam int SumW       = TempW + AddrW + 1;
  localparam int DivCntW    = $clog2(SumW + 1);

  // queue between front and back
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  typedef logic signed [TempW-1:0] temp_t;
  typedef logic signed [SumW-1:0]  sum_t;
  typedef logic [LenW-1:0]         len_t;
  typedef logic [AddrW-1:0]        addr_t;
  typedef logic [CfgW-1:0]         cfg_t;

  typedef struct packed {
    temp_t temperature;
    logic  last_of_sequence;
  } queue_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_TRACK,
    ST_HI_GO,
    ST_HI_WAIT,
    ST_LO_GO,
    ST_LO_WAIT,
    ST_RESULT
  } state_t;

endpackage

// File: src/swamm_ifs.sv
// Channel interfaces of the sliding window block: samples, results, config.
// Each carries valid, ready and its payload. Depends on swamm_pkg.
`timescale 1ns / 1ps

interface swamm_in_if;
  import swamm_pkg::*;
  logic  valid;
  logic  ready;
  temp_t temperature;
  logic  last_of_sequence;
  modport source (output valid, output temperature, output last_of_sequence, input ready);
  modport sink   (input valid, input temperature, input last_of_sequence, output ready);
endinterface

interface swamm_out_if;
  import swamm_pkg::*;
  logic  valid;
  logic  ready;
  temp_t max_average;
  temp_t min_average;
  logic  too_short;
  modport source (output valid, output max_average, output min_average, output too_short,
                  input ready);
  modport sink   (input valid, input max_average, input min_average, input too_short,
                  output ready);
endinterface

interface swamm_cfg_if;
  import swamm_pkg::*;
  logic valid;
  logic ready;
  cfg_t window_len;
  modport source (output valid, output window_len, input ready);
  modport sink   (input valid, input window_len, output ready);
endinterface

// File: src/swamm_div.sv
// Bit-serial signed divider: one quotient bit per cycle, truncates toward zero.
// Shared for both averages of a sequence. Depends on swamm_pkg.
`timescale 1ns / 1ps

module swamm_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  swamm_pkg::sum_t    dividend,
  input  swamm_pkg::len_t    divisor,
  output logic               done,
  output swamm_pkg::temp_t   quotient
);
  import swamm_pkg::*;

  logic [SumW-1:0]    quo;
  logic [LenW-1:0]    rem;
  logic [DivCntW-1:0] cnt;
  logic               busy;
  logic               neg;

  logic [LenW:0]      shifted;
  logic               ge;
  logic [LenW:0]      diff;
  logic [SumW-1:0]    signed_q;

  assign shifted  = {rem, quo[SumW-1]};
  assign ge       = shifted >= {1'b0, divisor};
  assign diff     = shifted - {1'b0, divisor};
  assign signed_q = neg ? (~quo + 1'b1) : quo;
  assign quotient = signed_q[TempW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DivCntW'(SumW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DivCntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: load magnitude, then shift in one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[SumW-1];
      quo <= dividend[SumW-1] ? (~dividend + 1'b1) : dividend;
      rem <= '0;
    end else if (busy) begin
      rem <= ge ? diff[LenW-1:0] : shifted[LenW-1:0];
      quo <= {quo[SumW-2:0], ge};
    end
  end

endmodule

// File: src/swamm_front.sv
// Front of the sliding window block: accepts samples into a short queue.
// Hands queue entries to the window engine. Depends on swamm_pkg, swamm_ifs.
`timescale 1ns / 1ps

module swamm_front (
  input  logic                    clk,
  input  logic                    rst,
  swamm_in_if.sink                samples,
  output logic                    q_valid,
  output swamm_pkg::queue_item_t  q_item,
  input  logic                    q_ready
);
  import swamm_pkg::*;

  queue_item_t       slots [QueueDepth];
  logic [QPtrW-1:0]  wr_ptr;
  logic [QPtrW-1:0]  rd_ptr;
  logic [QCntW-1:0]  count;
  logic              push;
  logic              pop;

  assign samples.ready = count != QCntW'(QueueDepth);
  assign push          = samples.valid && samples.ready;
  assign q_valid       = count != '0;
  assign pop           = q_valid && q_ready;
  assign q_item        = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{temperature: samples.temperature,
                         last_of_sequence: samples.last_of_sequence};
    end
  end

endmodule

// File: src/swamm_back.sv
// Window engine: window store, running sum, min/max tracking, result register.
// Uses swamm_div for the averages. Depends on swamm_pkg, swamm_ifs, swamm_div.
`timescale 1ns / 1ps

module swamm_back (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  swamm_pkg::cfg_t         cfg_data,
  input  logic                    q_valid,
  input  swamm_pkg::queue_item_t  q_item,
  output logic                    q_ready,
  swamm_out_if.source             results
);
  import swamm_pkg::*;

  temp_t  mem [WindowMax];

  state_t state;
  state_t state_next;

  addr_t  wp;
  len_t   len;
  len_t   fill;
  sum_t   run_sum;
  sum_t   max_sum;
  sum_t   min_sum;
  logic   have_win;
  temp_t  cur_temp;
  logic   cur_last;
  temp_t  rdata;
  temp_t  hi_q;
  temp_t  lo_q;

  logic   out_valid;
  temp_t  out_max;
  temp_t  out_min;
  logic   out_short;

  logic   pop;
  logic   mem_we;
  logic   div_go;
  logic   div_lo;
  logic   load_res;

  logic   full;
  logic   track_full;
  logic [LenW:0] old_full;
  addr_t  rd_addr;
  sum_t   sum_next;
  addr_t  wp_next;

  logic   div_done;
  temp_t  div_q;

  swamm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (div_lo ? min_sum : max_sum),
    .divisor  (len),
    .done     (div_done),
    .quotient (div_q)
  );

  assign full       = fill >= len;
  assign track_full = fill >= len;
  assign old_full   = (LenW+1)'(wp) + (LenW+1)'(WindowMax) - (LenW+1)'(len);
  assign rd_addr    = (old_full >= (LenW+1)'(WindowMax)) ?
                      AddrW'(old_full - (LenW+1)'(WindowMax)) : AddrW'(old_full);
  assign sum_next   = run_sum - (full ? SumW'(rdata) : '0) + SumW'(cur_temp);
  assign wp_next    = (wp == AddrW'(WindowMax - 1)) ? '0 : wp + 1'b1;

  assign results.valid       = out_valid;
  assign results.max_average = out_max;
  assign results.min_average = out_min;
  assign results.too_short   = out_short;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (q_valid) state_next = ST_SUM;
      ST_SUM:     state_next = ST_TRACK;
      ST_TRACK: begin
        if (!cur_last) begin
          state_next = ST_IDLE;
        end else if (have_win || track_full) begin
          state_next = ST_HI_GO;
        end else begin
          state_next = ST_RESULT;
        end
      end
      ST_HI_GO:   state_next = ST_HI_WAIT;
      ST_HI_WAIT: if (div_done) state_next = ST_LO_GO;
      ST_LO_GO:   state_next = ST_LO_WAIT;
      ST_LO_WAIT: if (div_done) state_next = ST_RESULT;
      ST_RESULT:  if (!out_valid || results.ready) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_ready  = 1'b0;
    mem_we   = 1'b0;
    div_go   = 1'b0;
    div_lo   = 1'b0;
    load_res = 1'b0;
    case (state)
      ST_IDLE:    q_ready = 1'b1;
      ST_SUM:     mem_we = 1'b1;
      ST_HI_GO:   div_go = 1'b1;
      ST_LO_GO: begin
        div_go = 1'b1;
        div_lo = 1'b1;
      end
      ST_RESULT:  load_res = !out_valid || results.ready;
      default:    q_ready = 1'b0;
    endcase
  end

  assign pop = q_valid && q_ready;

  // window store: read the oldest sample on pop in ST_IDLE, write the new one in ST_SUM
  always_ff @(posedge clk) begin
    if (pop) begin
      rdata <= mem[rd_addr];
    end
    if (mem_we) begin
      mem[wp] <= cur_temp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      len       <= LenW'(1);
      wp        <= '0;
      fill      <= '0;
      run_sum   <= '0;
      max_sum   <= '0;
      min_sum   <= '0;
      have_win  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (mem_we) begin
        run_sum <= sum_next;
        wp      <= wp_next;
        if (!full) begin
          fill <= fill + 1'b1;
        end
      end

      if (state == ST_TRACK && track_full) begin
        if (!have_win) begin
          max_sum  <= run_sum;
          min_sum  <= run_sum;
          have_win <= 1'b1;
        end else if (run_sum > max_sum) begin
          max_sum <= run_sum;
        end else if (run_sum < min_sum) begin
          min_sum <= run_sum;
        end
      end

      if (load_res) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end

      // sequence clear: after a result, or on any window length write
      if (load_res || cfg_we) begin
        wp       <= '0;
        fill     <= '0;
        run_sum  <= '0;
        max_sum  <= '0;
        min_sum  <= '0;
        have_win <= 1'b0;
      end

      if (cfg_we) begin
        if (cfg_data == '0) begin
          len <= LenW'(1);
        end else if (32'(cfg_data) > WindowMax) begin
          len <= LenW'(WindowMax);
        end else begin
          len <= LenW'(cfg_data);
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_temp <= q_item.temperature;
      cur_last <= q_item.last_of_sequence;
    end
    if (state == ST_HI_WAIT && div_done) begin
      hi_q <= div_q;
    end
    if (state == ST_LO_WAIT && div_done) begin
      lo_q <= div_q;
    end
    if (load_res) begin
      out_max   <= have_win ? hi_q : '0;
      out_min   <= have_win ? lo_q : '0;
      out_short <= !have_win;
    end
  end

endmodule

// File: src/sliding_window_average_min_max_top.sv
// Top level of the sliding window average / min / max block.
// Instantiates swamm_front and swamm_back; depends on swamm_pkg and swamm_ifs.
//
// Channel   Dir  Fields                                    Transaction when
// cfg       in   window_len[10:0]                          cfg.valid && cfg.ready
// samples   in   temperature[8:0] s, last_of_sequence      samples.valid && samples.ready
// results   out  max_average[8:0] s, min_average[8:0] s,   results.valid && results.ready
//                too_short
//
// In the engine each sample passes through these steps: read the oldest sample from the window store,
// update the running sum and write the new sample, update the extreme window sums.
// A last sample then adds two passes through one bit-serial divider of SumW = 20 bits,
// then a result load; a too-short sequence adds only the result load.
// A two-entry queue takes samples while the engine works; a waiting result stalls the engine
// only once the next result is ready. Reset is synchronous; the store is not cleared.
`timescale 1ns / 1ps

module sliding_window_average_min_max_top (
  input  logic       clk,
  input  logic       rst,
  swamm_cfg_if.sink  cfg,
  swamm_in_if.sink   samples,
  swamm_out_if.source results
);
  import swamm_pkg::*;

  logic        q_valid;
  logic        q_ready;
  queue_item_t q_item;
  logic        cfg_we;

  // window length writes are taken at once; they also restart the sequence
  assign cfg.ready = 1'b1;
  assign cfg_we    = cfg.valid && cfg.ready;

  // front: hold incoming samples in a short queue
  swamm_front u_front (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_ready (q_ready)
  );

  // back: advance the window, track extremes, divide at sequence end
  swamm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg.window_len),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_ready  (q_ready),
    .results  (results)
  );

endmodule

// File: src/swamm_chk.sv
// Port-level checks for the sliding window block, bound to its top level.
// Depends on swamm_pkg and the top level's ports.
`timescale 1ns / 1ps

module swamm_chk (
  input logic             clk,
  input logic             rst,
  input logic             r_valid,
  input logic             r_ready,
  input swamm_pkg::temp_t r_max,
  input swamm_pkg::temp_t r_min,
  input logic             r_short
);
  import swamm_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    r_valid && !r_ready |=> r_valid && $stable(r_max) && $stable(r_min) && $stable(r_short))
    else $error("result changed while stalled");

  // a short sequence reports zero averages
  a_short_zero: assert property (@(posedge clk) disable iff (rst)
    r_valid && r_short |-> r_max == '0 && r_min == '0)
    else $error("short sequence with non-zero averages");

  // largest average never below smallest
  a_order: assert property (@(posedge clk) disable iff (rst)
    r_valid && !r_short |-> r_max >= r_min)
    else $error("maximum average below minimum average");

  // nothing offered straight after reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !r_valid)
    else $error("result valid after reset");

endmodule

bind sliding_window_average_min_max_top swamm_chk u_swamm_chk (
  .clk     (clk),
  .rst     (rst),
  .r_valid (results.valid),
  .r_ready (results.ready),
  .r_max   (results.max_average),
  .r_min   (results.min_average),
  .r_short (results.too_short)
);
